// ===== sv/json_field_value_tagger_defines.svh =====
// Assertion macros used by the checker file of the field value tagger.
`ifndef JSON_FIELD_VALUE_TAGGER_DEFINES_SVH
`define JSON_FIELD_VALUE_TAGGER_DEFINES_SVH

// Assertion that is switched off while reset is held.
`define JFVT_ASSERT_RST(label, clk, rst_n, prop) \
  label: assert property (@(posedge clk) disable iff (!rst_n) prop) \
    else $error("json field value tagger check failed");

// Assertion that is also checked during reset.
`define JFVT_ASSERT_ALWAYS(label, clk, prop) \
  label: assert property (@(posedge clk) prop) \
    else $error("json field value tagger check failed");

`endif

// ===== sv/jfvt_pkg.sv =====
// Package of the field value tagger: sizes, key patterns and shared types.
package jfvt_pkg;

  localparam int FLIT_BYTES   = 8;
  localparam int KEY_LENGTH   = 11;
  localparam int KEY_COUNT    = 3;
  localparam int KEY_ROWS     = 3;
  localparam int WIN_LEN      = KEY_LENGTH + FLIT_BYTES;
  localparam int FLIT_WIDTH   = 64;
  localparam int TAGS_WIDTH   = 16;

  localparam logic [7:0] QUOTE_CHAR = 8'h22;
  localparam logic [7:0] WILD_CHAR  = 8'h2A;
  localparam logic [7:0] FILL_CHAR  = 8'hFF;

  // Key patterns, first character at index 0; a star matches any byte.
  localparam logic [7:0] KEY_TABLE [KEY_ROWS][KEY_LENGTH] = '{
    '{8'h22, 8'h73, 8'h79, 8'h73, 8'h63, 8'h61, 8'h6C, 8'h6C, 8'h22, 8'h3A, 8'h20},
    '{8'h2A, 8'h2A, 8'h2A, 8'h2A, 8'h22, 8'h65, 8'h78, 8'h65, 8'h22, 8'h3A, 8'h20},
    '{8'h2A, 8'h2A, 8'h2A, 8'h22, 8'h70, 8'h61, 8'h74, 8'h68, 8'h22, 8'h3A, 8'h20}
  };

  typedef logic [KEY_LENGTH-1:0][7:0] hist_t;
  typedef logic [WIN_LEN-1:0][7:0]    window_t;

  typedef struct packed {
    logic [TAGS_WIDTH-1:0] tags;
    logic                  has_quote;
    logic [1:0]            ovf_nxt;
    hist_t                 hist_nxt;
  } jfvt_result_t;

  // OR of the 1-based key indices whose pattern equals the window.
  function automatic logic [1:0] fresh_tag(input hist_t w);
    logic [1:0] tag;
    logic       hit;
    tag = '0;
    for (int i = 0; i < KEY_COUNT; i++) begin
      hit = 1'b1;
      for (int j = 0; j < KEY_LENGTH; j++) begin
        if (KEY_TABLE[i][j] != WILD_CHAR && w[j] != KEY_TABLE[i][j]) begin
          hit = 1'b0;
        end
      end
      if (hit) begin
        tag = tag | 2'(i + 1);
      end
    end
    return tag;
  endfunction

endpackage

// ===== sv/json_field_value_tagger.sv =====
// Top level of the field value tagger: input stage, tag state and result register.
//
// Input channel: in_valid / in_ready move one flit of eight bytes, byte 0 in the
// low bits, with its end-of-packet flag. Result channel: out_valid / out_ready
// move the same flit, a 2-bit tag per byte (0 misc, 1 syscall, 2 exe, 3 path),
// the quote flag and the end-of-packet flag.
// Every input transfer yields exactly one result transfer, in order.
// Path: a flit taken on the input channel goes through the input register and then
// the result register before it is shown on the result channel.
// Throughput: one flit per cycle while the receiver takes results; the match, carry
// and overflow logic sit in one combinational pass between the two registers.
// The history of the last eleven bytes and the overflow tag advance when a flit
// moves from the input register to the result register.
// Reset (rst_n low, synchronous) empties both registers, clears the history to
// zero bytes and the overflow tag to misc.
// When the receiver stalls, the result register holds; the input register still
// takes one more flit, and in_ready then drops until the result is taken.
module json_field_value_tagger (
  input  logic                            clk,
  input  logic                            rst_n,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [jfvt_pkg::FLIT_WIDTH-1:0] in_flit_bytes,
  input  logic                            in_end_of_packet,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [jfvt_pkg::FLIT_WIDTH-1:0] out_flit_bytes_out,
  output logic [jfvt_pkg::TAGS_WIDTH-1:0] out_byte_tags,
  output logic                            out_has_quote,
  output logic                            out_end_of_packet_out
);
  import jfvt_pkg::*;

  logic                  stg_v_r;
  logic [FLIT_WIDTH-1:0] stg_flit_r;
  logic                  stg_eop_r;
  logic                  out_v_r;
  logic [FLIT_WIDTH-1:0] out_flit_r;
  logic [TAGS_WIDTH-1:0] out_tags_r;
  logic                  out_quote_r;
  logic                  out_eop_r;
  hist_t                 hist_r;
  logic [1:0]            ovf_r;
  logic                  advance;
  logic                  in_fire;
  jfvt_result_t          res;

  assign advance  = stg_v_r && (!out_v_r || out_ready);
  assign in_ready = !stg_v_r || advance;
  assign in_fire  = in_valid && in_ready;

  jfvt_tagger u_tagger (
    .flit    (stg_flit_r),
    .eop     (stg_eop_r),
    .hist    (hist_r),
    .ovf_tag (ovf_r),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      stg_v_r <= 1'b0;
      out_v_r <= 1'b0;
      hist_r  <= '0;
      ovf_r   <= '0;
    end else begin
      if (in_fire) begin
        stg_v_r <= 1'b1;
      end else if (advance) begin
        stg_v_r <= 1'b0;
      end
      if (advance) begin
        out_v_r <= 1'b1;
        hist_r  <= res.hist_nxt;
        ovf_r   <= res.ovf_nxt;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      stg_flit_r <= in_flit_bytes;
      stg_eop_r  <= in_end_of_packet;
    end
    if (advance) begin
      out_flit_r  <= stg_flit_r;
      out_tags_r  <= res.tags;
      out_quote_r <= res.has_quote;
      out_eop_r   <= stg_eop_r;
    end
  end

  assign out_valid             = out_v_r;
  assign out_flit_bytes_out    = out_flit_r;
  assign out_byte_tags         = out_tags_r;
  assign out_has_quote         = out_quote_r;
  assign out_end_of_packet_out = out_eop_r;

endmodule

// ===== sv/jfvt_tagger.sv =====
// Tag logic of one flit: key matching, in-flit carry, overflow OR and next state.
module jfvt_tagger (
  input  logic [jfvt_pkg::FLIT_WIDTH-1:0] flit,
  input  logic                            eop,
  input  jfvt_pkg::hist_t                 hist,
  input  logic [1:0]                      ovf_tag,
  output jfvt_pkg::jfvt_result_t          res
);
  import jfvt_pkg::*;

  window_t    win;
  logic [1:0] fresh [FLIT_BYTES];
  logic [1:0] tag1  [FLIT_BYTES];
  logic [1:0] carry;
  logic [1:0] ov;
  logic [1:0] last;
  logic       quote_seen;

  always_comb begin
    for (int k = 0; k < KEY_LENGTH; k++) begin
      win[k] = hist[k];
    end
    for (int i = 0; i < FLIT_BYTES; i++) begin
      win[KEY_LENGTH + i] = flit[8*i +: 8];
    end
    for (int i = 0; i < FLIT_BYTES; i++) begin
      fresh[i] = fresh_tag(win[i +: KEY_LENGTH]);
    end
  end

  // An untagged quote ends the carried tag inside the flit.
  always_comb begin
    carry      = '0;
    quote_seen = 1'b0;
    for (int i = 0; i < FLIT_BYTES; i++) begin
      tag1[i] = fresh[i] | carry;
      carry   = tag1[i];
      if (fresh[i] == 2'b00 && flit[8*i +: 8] == QUOTE_CHAR) begin
        carry      = '0;
        quote_seen = 1'b1;
      end
    end
    last = tag1[FLIT_BYTES-1];
  end

  // The tag from earlier flits reaches every byte up to the first quote.
  always_comb begin
    res.tags = '0;
    ov       = ovf_tag;
    for (int i = 0; i < FLIT_BYTES; i++) begin
      res.tags[2*i +: 2] = tag1[i] | ov;
      if (flit[8*i +: 8] == QUOTE_CHAR) begin
        ov = '0;
      end
    end
    res.has_quote = quote_seen;
    if (eop) begin
      res.ovf_nxt = '0;
      for (int k = 0; k < KEY_LENGTH; k++) begin
        res.hist_nxt[k] = FILL_CHAR;
      end
    end else begin
      res.ovf_nxt  = (quote_seen || last != 2'b00) ? last : ovf_tag;
      res.hist_nxt = win[FLIT_BYTES +: KEY_LENGTH];
    end
  end

endmodule

// ===== sv/jfvt_checker.sv =====
// Port checks of the field value tagger and the bind that attaches them.
`include "json_field_value_tagger_defines.svh"

module jfvt_checker (
  input logic                            clk,
  input logic                            rst_n,
  input logic                            in_valid,
  input logic                            in_ready,
  input logic [jfvt_pkg::FLIT_WIDTH-1:0] in_flit_bytes,
  input logic                            in_end_of_packet,
  input logic                            out_valid,
  input logic                            out_ready,
  input logic [jfvt_pkg::FLIT_WIDTH-1:0] out_flit_bytes_out,
  input logic [jfvt_pkg::TAGS_WIDTH-1:0] out_byte_tags,
  input logic                            out_has_quote,
  input logic                            out_end_of_packet_out
);
  import jfvt_pkg::*;

  logic any_quote;
  logic pkt_start_r;

  always_comb begin
    any_quote = 1'b0;
    for (int i = 0; i < FLIT_BYTES; i++) begin
      if (out_flit_bytes_out[8*i +: 8] == QUOTE_CHAR) begin
        any_quote = 1'b1;
      end
    end
  end

  // Set while the next result is the first flit after reset or after a packet end.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pkt_start_r <= 1'b1;
    end else if (out_valid && out_ready) begin
      pkt_start_r <= out_end_of_packet_out;
    end
  end

  `JFVT_ASSERT_ALWAYS(a_reset_empties, clk, !rst_n |=> !out_valid)
  `JFVT_ASSERT_RST(a_in_hold, clk, rst_n,
    in_valid && !in_ready |=> in_valid && $stable(in_flit_bytes) && $stable(in_end_of_packet))
  `JFVT_ASSERT_RST(a_out_hold, clk, rst_n,
    out_valid && !out_ready |=> out_valid && $stable(out_flit_bytes_out))
  `JFVT_ASSERT_RST(a_quote_flag, clk, rst_n, out_valid && out_has_quote |-> any_quote)
  `JFVT_ASSERT_RST(a_first_byte_plain, clk, rst_n,
    out_valid && pkt_start_r |-> out_byte_tags[1:0] == 2'b00)

endmodule

bind json_field_value_tagger jfvt_checker u_jfvt_checker (.*);
